// ===== rtl/core/pidd_pkg.sv =====
// ============================================================================
// pidd_pkg
// Shared types and constants of the PID controller with dead band: the
// configuration register set, register indexes and status codes.
// ============================================================================
package pidd_pkg;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	// Fixed field widths.
	localparam int GAIN_W  = 24;
	localparam int LIMIT_W = 16;
	localparam int DRIVE_W = 17;
	localparam int STATUS_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_I_GAIN         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN         = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERROR      = 3'd6;

	// Status codes reported with each drive value.
	localparam logic [STATUS_W-1:0] STATUS_NORMAL    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVER_MAX  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEAD_BAND = 2'd2;

	// Register set seen by the datapath. Gains are two's complement Q8.16.
	typedef struct packed {
		logic [GAIN_W-1:0]  p_gain;
		logic [GAIN_W-1:0]  i_gain;
		logic [GAIN_W-1:0]  d_gain;
		logic [LIMIT_W-1:0] integral_limit;
		logic [LIMIT_W-1:0] output_limit;
		logic [LIMIT_W-1:0] dead_band;
		logic [LIMIT_W-1:0] max_error;
	} cfg_t;

endpackage

// ===== rtl/core/pidd_cfg_regs.sv =====
// ============================================================================
// pidd_cfg_regs
// Configuration register file. Takes single-cycle writes by index and
// presents the whole register set to the datapath.
// ============================================================================
module pidd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pidd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pidd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pidd_pkg::cfg_t                    cfg
);
	import pidd_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P_GAIN:         cfg_q.p_gain         <= cfg_wdata[GAIN_W-1:0];
				REG_I_GAIN:         cfg_q.i_gain         <= cfg_wdata[GAIN_W-1:0];
				REG_D_GAIN:         cfg_q.d_gain         <= cfg_wdata[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata[LIMIT_W-1:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_wdata[LIMIT_W-1:0];
				REG_DEAD_BAND:      cfg_q.dead_band      <= cfg_wdata[LIMIT_W-1:0];
				REG_MAX_ERROR:      cfg_q.max_error      <= cfg_wdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pidd_datapath.sv =====
// ============================================================================
// pidd_datapath
// Single-pass PID arithmetic: error window check, P, I and D terms, integral
// and output clamps, and the integral and last-error state registers.
// ============================================================================
module pidd_datapath #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidd_pkg::cfg_t                    cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]    measured,
	input  logic signed [SAMPLE_WIDTH-1:0]    target,
	input  logic                              update,
	output logic signed [pidd_pkg::DRIVE_W-1:0]  drive,
	output logic [pidd_pkg::STATUS_W-1:0]     status
);
	import pidd_pkg::*;

	// Error and its magnitude.
	localparam int EW = SAMPLE_WIDTH + 1;
	localparam int MW = (EW > LIMIT_W) ? EW : LIMIT_W;
	// Products: P and I use the error, D uses the error difference.
	localparam int PW = GAIN_W + EW;
	localparam int DW = GAIN_W + EW + 1;
	// Integral state and its pre-clamp sum.
	localparam int IW = LIMIT_W + GAIN_FRAC_BITS + 1;
	localparam int IS = ((IW > PW) ? IW : PW) + 1;
	// Total sum of the three terms.
	localparam int SM0 = (PW > DW) ? PW : DW;
	localparam int SW  = ((SM0 > IW) ? SM0 : IW) + 2;

	logic signed [GAIN_W-1:0] p_gain_s;
	logic signed [GAIN_W-1:0] i_gain_s;
	logic signed [GAIN_W-1:0] d_gain_s;
	logic signed [EW-1:0]     err;
	logic [EW-1:0]            mag;
	logic [MW-1:0]            mag_ext;
	logic                     over_max;
	logic                     in_band;
	logic signed [PW-1:0]     pterm;
	logic signed [PW-1:0]     iprod;
	logic signed [EW:0]       derr;
	logic signed [DW-1:0]     dterm;
	logic signed [IS-1:0]     integ_raw;
	logic signed [IS-1:0]     ilim_pos;
	logic signed [IS-1:0]     integ_clamp;
	logic signed [IW-1:0]     integ_next;
	logic signed [SW-1:0]     sum_raw;
	logic signed [SW-1:0]     olim_pos;
	logic signed [SW-1:0]     sum_clamp;
	logic signed [IW-1:0]     integral_q;
	logic signed [EW-1:0]     last_error_q;

	assign p_gain_s = $signed(cfg.p_gain);
	assign i_gain_s = $signed(cfg.i_gain);
	assign d_gain_s = $signed(cfg.d_gain);

	// Error and magnitude; the magnitude always fits EW bits unsigned.
	assign err     = EW'(target) - EW'(measured);
	assign mag     = err[EW-1] ? EW'(-err) : EW'(err);
	assign mag_ext = MW'(mag);

	// Window checks; a limit of zero disables its check.
	assign over_max = (cfg.max_error != '0) && (mag_ext > MW'(cfg.max_error));
	assign in_band  = (cfg.dead_band != '0) && (mag_ext < MW'(cfg.dead_band));

	// The three independent products.
	assign pterm = PW'(p_gain_s) * PW'(err);
	assign iprod = PW'(i_gain_s) * PW'(err);
	assign derr  = (EW + 1)'(err) - (EW + 1)'(last_error_q);
	assign dterm = DW'(d_gain_s) * DW'(derr);

	// Integral accumulate and symmetric clamp.
	assign integ_raw = IS'(integral_q) + IS'(iprod);
	assign ilim_pos  = IS'($signed({1'b0, cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}}));
	always_comb begin
		if (integ_raw > ilim_pos) begin
			integ_clamp = ilim_pos;
		end else if (integ_raw < -ilim_pos) begin
			integ_clamp = -ilim_pos;
		end else begin
			integ_clamp = integ_raw;
		end
	end
	assign integ_next = IW'(integ_clamp);

	// Output sum and symmetric clamp.
	assign sum_raw  = SW'(pterm) + SW'(integ_next) + SW'(dterm);
	assign olim_pos = SW'($signed({1'b0, cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}}));
	always_comb begin
		if (sum_raw > olim_pos) begin
			sum_clamp = olim_pos;
		end else if (sum_raw < -olim_pos) begin
			sum_clamp = -olim_pos;
		end else begin
			sum_clamp = sum_raw;
		end
	end

	// Result selection; max_error wins over the dead band.
	always_comb begin
		priority if (over_max) begin
			status = STATUS_OVER_MAX;
			drive  = '0;
		end else if (in_band) begin
			status = STATUS_DEAD_BAND;
			drive  = '0;
		end else begin
			status = STATUS_NORMAL;
			drive  = DRIVE_W'(sum_clamp >>> GAIN_FRAC_BITS);
		end
	end

	// Controller state moves only on a normal item leaving the pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
		end else if (update && !over_max && !in_band) begin
			integral_q   <= integ_next;
			last_error_q <= err;
		end
	end

endmodule

// ===== rtl/core/pid_controller_with_deadband_top.sv =====
// ============================================================================
// pid_controller_with_deadband_top
// Positional PID controller with dead band and error window, stream ports.
// ============================================================================
// Usage:
// Samples enter on the s_ channel: s_tdata carries measured and target.
// Each accepted sample yields exactly one result on the m_ channel: the
// clamped drive in m_tdata and a status code in m_tuser (normal, error above
// max_error, or error inside the dead band). Gains and limits are set over
// the cfg_ write port, one register per cycle, while no sample is in flight.
// An accepted sample sits in the input register; when the output register is
// free or draining, its result is loaded into the output register, which
// drives m_tvalid. Throughput is one sample per cycle while the receiver
// does not stall; the multiply, accumulate and clamp path from the input
// register to the output register and the controller state sets the clock
// rate.
// When the receiver stalls, the result holds in the output register and the
// input register can still take one more sample; only then is s_tready low.
// Reset clears all gains and limits, the integral and last error, and both
// valid flags; payload registers are not cleared.
// ============================================================================
module pid_controller_with_deadband_top #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [pidd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pidd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Sample input: measured, then target.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,   // measured, target
	// Result output: m_tdata holds drive; m_tuser holds status.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,   // [16:0] drive, [23:17] zero
	output logic [pidd_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
	import pidd_pkg::*;

	localparam int OUT_PAD = 24 - DRIVE_W;

	cfg_t                          cfg;
	logic                          valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;
	logic signed [SAMPLE_WIDTH-1:0] target_s1;
	logic                          advance;
	logic signed [DRIVE_W-1:0]     drive_d;
	logic [STATUS_W-1:0]           status_d;
	logic                          out_valid_q;
	logic signed [DRIVE_W-1:0]     drive_q;
	logic [STATUS_W-1:0]           status_q;

	pidd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The input register moves on when the output register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			measured_s1 <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
			target_s1   <= $signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
		end
	end

	pidd_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.measured (measured_s1),
		.target   (target_s1),
		.update   (advance),
		.drive    (drive_d),
		.status   (status_d)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q  <= drive_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, drive_q};
	assign m_tuser  = status_q;

	// A sample is refused only while both registers are full and the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while the pass was blocked");

	// A window hit always reports zero drive.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != STATUS_NORMAL)) |-> (m_tdata == '0))
		else $error("nonzero drive with a window status");

	// Status never carries the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_NORMAL || m_tuser == STATUS_OVER_MAX ||
			m_tuser == STATUS_DEAD_BAND))
		else $error("undefined status code");

	// A result that moves through the pass shows up at the output next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost between pass and output register");

endmodule

// ===== tb/sv/pid_controller_with_deadband_top_tb.sv =====
// ----------------------------------------------------------------------------
// PID controller with dead band: stream-level testbench
// Sends sample pairs through the stream input while random stalls fall on
// both sides. A scoreboard class keeps its own copy of the gains, limits,
// integral and last error. It predicts drive and status for every accepted
// sample and compares each result transaction in order. The run covers
// several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module pid_controller_with_deadband_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pidd_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
	// An index past the end of the register list; writes to it are dropped.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 4;

	// Keeps the controller state and the drive/status values still owed by the block.
	class drive_tracker;
		cfg_t regs;
		longint integ_acc;
		longint prev_err;
		logic [DRIVE_W-1:0]  drive_q[$];
		logic [STATUS_W-1:0] status_q[$];
		int errors;

		function new();
			regs      = '0;
			integ_acc = 0;
			prev_err  = 0;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_P_GAIN:         regs.p_gain = val;
				REG_I_GAIN:         regs.i_gain = val;
				REG_D_GAIN:         regs.d_gain = val;
				REG_INTEGRAL_LIMIT: regs.integral_limit = val[LIMIT_W-1:0];
				REG_OUTPUT_LIMIT:   regs.output_limit = val[LIMIT_W-1:0];
				REG_DEAD_BAND:      regs.dead_band = val[LIMIT_W-1:0];
				REG_MAX_ERROR:      regs.max_error = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_sym(longint x, longint lim);
			if (x > lim)
				return lim;
			if (x < -lim)
				return -lim;
			return x;
		endfunction

		function void flag_error(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// Works out the result of one accepted sample and updates the state.
		function void note_sample(logic signed [SAMPLE_W-1:0] meas,
				logic signed [SAMPLE_W-1:0] targ);
			longint err, mag, pterm, dterm, total;
			longint max_err, dband;
			logic [DRIVE_W-1:0]  drv;
			logic [STATUS_W-1:0] st;
			err     = longint'(targ) - longint'(meas);
			mag     = (err < 0) ? -err : err;
			max_err = longint'(regs.max_error);
			dband   = longint'(regs.dead_band);
			drv     = '0;
			if (max_err != 0 && mag > max_err) begin
				st = STATUS_OVER_MAX;
			end else if (dband != 0 && mag < dband) begin
				st = STATUS_DEAD_BAND;
			end else begin
				st        = STATUS_NORMAL;
				pterm     = longint'($signed(regs.p_gain)) * err;
				integ_acc = clamp_sym(integ_acc + longint'($signed(regs.i_gain)) * err,
					longint'(regs.integral_limit) <<< FRAC_W);
				dterm     = longint'($signed(regs.d_gain)) * (err - prev_err);
				total     = clamp_sym(pterm + integ_acc + dterm,
					longint'(regs.output_limit) <<< FRAC_W);
				drv       = DRIVE_W'(total >>> FRAC_W);
				prev_err  = err;
			end
			drive_q.push_back(drv);
			status_q.push_back(st);
		endfunction

		// Compares one result transaction with the oldest prediction.
		function void check_drive(logic [DRIVE_W-1:0] drv, logic [STATUS_W-1:0] st);
			logic [DRIVE_W-1:0]  drv_exp;
			logic [STATUS_W-1:0] st_exp;
			if (drive_q.size() == 0) begin
				flag_error($sformatf("result drive=%0d status=%0d with no sample pending",
					$signed(drv), st));
				return;
			end
			drv_exp = drive_q.pop_front();
			st_exp  = status_q.pop_front();
			if (drv !== drv_exp)
				flag_error($sformatf("drive expected %0d, got %0d",
					$signed(drv_exp), $signed(drv)));
			if (st !== st_exp)
				flag_error($sformatf("status expected %0d, got %0d", st_exp, st));
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_INDEX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_wdata;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [TDATA_W-1:0]           s_tdata;   // [15:0] measured, [31:16] target
	logic                         m_tvalid;
	logic                         m_tready;
	logic [23:0]                  m_tdata;   // [16:0] drive, [23:17] zero
	logic [STATUS_W-1:0]          m_tuser;   // [1:0] status

	drive_tracker sb;
	bit calm;

	pid_controller_with_deadband_top #(
		.SAMPLE_WIDTH  (SAMPLE_W),
		.GAIN_FRAC_BITS(FRAC_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mirror register writes, input transactions and result transactions.
	always @(posedge clk) begin
		if (arst_n && cfg_we)
			sb.set_reg(cfg_index, cfg_wdata);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_sample(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata[DRIVE_W-1:0], m_tuser);
	end

	// Receiver: random stall bursts until the calm stretch at the end.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Present one sample and hold it until the block takes it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] meas, input logic [SAMPLE_W-1:0] targ);
		s_tvalid <= 1'b1;
		s_tdata  <= {targ, meas};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic sample(input int meas, input int targ);
		send_sample(SAMPLE_W'(meas), SAMPLE_W'(targ));
		maybe_idle();
	endtask

	// Stop sending and wait until every predicted result has come back. The
	// first edge lets the scoreboard record a sample taken at the last edge.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Drain the pipeline, then write the whole register set, plus one write to the spare index.
	task automatic load_settings(input int p, input int i, input int d,
			input int il, input int ol, input int db, input int me);
		drain();
		write_reg(REG_P_GAIN, CFG_DATA_W'(p));
		write_reg(REG_I_GAIN, CFG_DATA_W'(i));
		write_reg(REG_D_GAIN, CFG_DATA_W'(d));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(il));
		write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(ol));
		write_reg(REG_DEAD_BAND, CFG_DATA_W'(db));
		write_reg(REG_MAX_ERROR, CFG_DATA_W'(me));
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_gain();
		case ($urandom_range(0, 9))
			0: return -8388608;
			1: return 8388607;
			2: return int'($urandom_range(0, 1 << 24)) - (1 << 23);
			default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
		endcase
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			default: return int'($urandom_range(1, 4000));
		endcase
	endfunction

	// Mostly near-setpoint samples so the windows let most of them through.
	task automatic random_sample();
		int targ, meas;
		targ = int'($urandom_range(0, 65535)) - 32768;
		if ($urandom_range(0, 3) == 0) begin
			meas = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			meas = targ - (int'($urandom_range(0, 800)) - 400);
			if (meas > 32767)
				meas = 32767;
			if (meas < -32768)
				meas = -32768;
		end
		sample(meas, targ);
	endtask

	task automatic random_phase(input int count);
		int db, me;
		db = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 60));
		me = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(50, 1000));
		load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
			db, me);
		for (int n = 0; n < count; n++) begin
			random_sample();
			// Once in a while hold off until the pipeline is empty.
			if (n == count / 2 && $urandom_range(0, 1) == 0)
				drain();
		end
	endtask

	initial begin
		sb        = new();
		calm      = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: output limit zero forces zero drive.
		sample(-32768, 32767);
		sample(32767, -32768);

		// Moderate gains, no windows; extreme errors in both directions.
		load_settings(65536, 16384, 32768, 1000, 65535, 0, 0);
		sample(0, 0);
		sample(-32768, 32767);
		sample(32767, -32768);
		sample(100, 120);
		sample(5, 5);

		// Extreme gains and limits.
		load_settings(-8388608, 8388607, 8388607, 65535, 65535, 0, 0);
		sample(-32768, 32767);
		sample(32767, -32768);
		sample(0, 1);

		// Integral limit zero keeps the integral at zero.
		load_settings(65536, 65536, 0, 0, 500, 0, 0);
		sample(0, 300);
		sample(0, -300);
		sample(0, 1000);

		// Both windows hit at once: the max-error check wins.
		load_settings(65536, 0, 0, 0, 65535, 100, 10);
		sample(0, 50);
		sample(0, 5);
		sample(0, -10);
		sample(0, 200);

		// Errors equal to a window edge are normal; window hits leave the state alone.
		load_settings(65536, 65536, 65536, 100, 1000, 5, 300);
		sample(0, 5);
		sample(0, 300);
		sample(0, -301);
		sample(0, 4);
		sample(0, -5);
		sample(10, 7);
		sample(0, 6);

		// Random settings and samples; the last phase runs without stalls.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				drain();
				calm = 1'b1;
			end
			random_phase(105);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
